// ===== rtl/lkvc_pkg.sv =====
`timescale 1ns / 1ps
// lkvc_pkg: operation codes and fixed field widths for the LRU key-value cache.
// Used by lru_key_value_cache and lkvc_checker; depends on nothing.
package lkvc_pkg;

    // Operation carried by each input transfer
    typedef enum logic [1:0] {
        MODE_GET   = 2'd0,
        MODE_PUT   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_PROBE = 2'd3
    } t_mode;

    localparam int MODE_W = 2;
    localparam int CAP_W  = 5;
    localparam int OCC_W  = 5;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd10;

    // Bit positions of the flags in the result tuser
    localparam int UF_HIT     = 0;
    localparam int UF_EVICTED = 1;
    localparam int OUT_USER_W = 2;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// lru_key_value_cache: fully associative key-value store with LRU replacement.
// Depends on lkvc_pkg for operation codes and fixed field widths.
//
//  channel   | direction | tdata (low bit first)                        | tuser
//  ----------+-----------+----------------------------------------------+--------------
//  s_axis    | in        | key, write_value, zero fill                  | mode
//  m_axis    | out       | read_value, evicted_key, occupancy, is_full  | hit, evicted
//  cfg       | in        | i_cfg_wdata = capacity (no handshake)        | -
//
//  One transfer per cycle sustained while results are taken: an input register feeds a single
//  pass of tag compare, age-rank update and slot pick (all entries in parallel), and the
//  result register holds the answer.
//  Synchronous active-low reset empties the store and sets capacity to 10.
//  A stalled result holds the pipe; the input register still takes one transfer meanwhile.
module lru_key_value_cache #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    localparam int IN_W      = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((VALUE_BITS + KEY_BITS + lkvc_pkg::OCC_W + 1 + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // capacity register write
    input  logic                            i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]      i_cfg_wdata,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [IN_W-1:0]                 s_axis_tdata,  // key, write_value
    input  logic [lkvc_pkg::MODE_W-1:0]     s_axis_tuser,  // mode
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [OUT_W-1:0]                m_axis_tdata,  // read_value, evicted_key,
                                                           // occupancy, is_full
    output logic [lkvc_pkg::OUT_USER_W-1:0] m_axis_tuser   // hit, evicted
);

    localparam int RW    = $clog2(ENTRIES);
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CW > lkvc_pkg::CAP_W) ? CW : lkvc_pkg::CAP_W;

    // Configuration
    logic [lkvc_pkg::CAP_W-1:0] r_capacity;

    // Input register
    logic                  r_in_valid;
    lkvc_pkg::t_mode       r_in_mode;
    logic [KEY_BITS-1:0]   r_in_key;
    logic [VALUE_BITS-1:0] r_in_value;

    // Store
    logic [ENTRIES-1:0]    r_valid, n_valid;
    logic [RW-1:0]         r_rank [ENTRIES], n_rank [ENTRIES];
    logic [CW-1:0]         r_count, n_count;
    logic [KEY_BITS-1:0]   r_key [ENTRIES];
    logic [VALUE_BITS-1:0] r_value [ENTRIES];

    // Result register
    logic                  r_out_valid;
    logic                  r_out_hit, n_out_hit;
    logic                  r_out_evicted, n_out_evicted;
    logic [VALUE_BITS-1:0] r_out_rd, n_out_rd;
    logic [KEY_BITS-1:0]   r_out_evk, n_out_evk;
    logic [lkvc_pkg::OCC_W-1:0] r_out_occ, n_out_occ;
    logic                  r_out_full, n_out_full;

    // Lookup terms
    logic                  advance;
    logic [ENTRIES-1:0]    hit_oh, free_oh, old_oh, touch_oh, ins_oh, wr_oh;
    logic [RW-1:0]         hit_idx, old_idx, touch_rank, cnt_m1;
    logic                  any_hit, has_room;
    logic                  do_touch, do_insert, do_clear;
    logic [CMP_W-1:0]      cap_ext, cap_eff, cnt_ext, n_cnt_ext;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Clamp capacity to 1..ENTRIES
    assign cap_ext = CMP_W'(r_capacity);
    always_comb begin
        priority if (r_capacity == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = cap_ext;
        end
    end

    assign cnt_ext  = CMP_W'(r_count);
    assign has_room = cnt_ext < cap_eff;
    assign cnt_m1   = RW'(r_count - CW'(1));

    // Parallel tag compare, free slot and least recent slot
    assign free_oh = ~r_valid & (~(~r_valid) + ENTRIES'(1));
    always_comb begin
        hit_idx = '0;
        old_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            hit_oh[i] = r_valid[i] && (r_key[i] == r_in_key);
            old_oh[i] = r_valid[i] && (r_rank[i] == cnt_m1);
            if (hit_oh[i]) hit_idx |= RW'(i);
            if (old_oh[i]) old_idx |= RW'(i);
        end
        any_hit = |hit_oh;
    end

    // Pick the operation on the store
    always_comb begin
        do_clear      = 1'b0;
        do_touch      = 1'b0;
        do_insert     = 1'b0;
        touch_oh      = '0;
        ins_oh        = '0;
        wr_oh         = '0;
        n_out_hit     = 1'b0;
        n_out_evicted = 1'b0;
        n_out_rd      = '0;
        n_out_evk     = '0;
        unique case (r_in_mode)
            lkvc_pkg::MODE_CLEAR: begin
                do_clear = advance;
            end
            lkvc_pkg::MODE_GET: begin
                n_out_hit = any_hit;
                if (any_hit) begin
                    n_out_rd = r_value[hit_idx];
                    do_touch = advance;
                    touch_oh = hit_oh;
                end
            end
            lkvc_pkg::MODE_PROBE: begin
                n_out_hit = any_hit;
                if (any_hit) n_out_rd = r_value[hit_idx];
            end
            lkvc_pkg::MODE_PUT: begin
                n_out_hit = any_hit;
                if (any_hit) begin
                    do_touch = advance;
                    touch_oh = hit_oh;
                    wr_oh    = advance ? hit_oh : '0;
                end else if (has_room) begin
                    do_insert = advance;
                    ins_oh    = free_oh;
                    wr_oh     = advance ? free_oh : '0;
                end else begin
                    n_out_evicted = 1'b1;
                    n_out_evk     = r_key[old_idx];
                    do_touch      = advance;
                    touch_oh      = old_oh;
                    wr_oh         = advance ? old_oh : '0;
                end
            end
            default: begin
                do_clear = 1'b0;
            end
        endcase
    end

    // Rank of the slot being made most recent
    always_comb begin
        touch_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (touch_oh[i]) touch_rank |= r_rank[i];
        end
    end

    // Update valid bits, age ranks and count
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (do_clear) begin
                n_valid[i] = 1'b0;
                n_rank[i]  = '0;
            end else if (do_insert) begin
                if (ins_oh[i]) begin
                    n_valid[i] = 1'b1;
                    n_rank[i]  = '0;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + RW'(1);
                end
            end else if (do_touch) begin
                if (touch_oh[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < touch_rank)) begin
                    n_rank[i] = r_rank[i] + RW'(1);
                end
            end
        end
        if (do_clear) begin
            n_count = '0;
        end else if (do_insert) begin
            n_count = r_count + CW'(1);
        end
    end

    assign n_cnt_ext  = CMP_W'(n_count);
    assign n_out_occ  = lkvc_pkg::OCC_W'(n_count);
    assign n_out_full = n_cnt_ext >= cap_eff;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lkvc_pkg::CAPACITY_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_mode  <= lkvc_pkg::t_mode'(s_axis_tuser);
            r_in_key   <= s_axis_tdata[KEY_BITS-1:0];
            r_in_value <= s_axis_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS];
        end
    end

    // Store control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < ENTRIES; i++) r_rank[i] <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            for (int i = 0; i < ENTRIES; i++) r_rank[i] <= n_rank[i];
        end
    end

    // Store keys and values
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (wr_oh[i]) begin
                r_key[i]   <= r_in_key;
                r_value[i] <= r_in_value;
            end
        end
    end

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_hit     <= n_out_hit;
            r_out_evicted <= n_out_evicted;
            r_out_rd      <= n_out_rd;
            r_out_evk     <= n_out_evk;
            r_out_occ     <= n_out_occ;
            r_out_full    <= n_out_full;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_full, r_out_occ, r_out_evk, r_out_rd});
    always_comb begin
        m_axis_tuser                       = '0;
        m_axis_tuser[lkvc_pkg::UF_HIT]     = r_out_hit;
        m_axis_tuser[lkvc_pkg::UF_EVICTED] = r_out_evicted;
    end

endmodule

// ===== rtl/lkvc_checker.sv =====
`timescale 1ns / 1ps
// lkvc_checker: port-level assertions for lru_key_value_cache, bound to the top level.
// Depends on lkvc_pkg for the result flag positions and field widths.
module lkvc_checker #(
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    parameter int OUT_W      = 72
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [OUT_W-1:0]                m_axis_tdata,
    input logic [lkvc_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    localparam int OCC_LO  = VALUE_BITS + KEY_BITS;
    localparam int FULL_AT = OCC_LO + lkvc_pkg::OCC_W;

    logic                       hit, evicted, is_full;
    logic [VALUE_BITS-1:0]      read_value;
    logic [lkvc_pkg::OCC_W-1:0] occupancy;

    assign hit        = m_axis_tuser[lkvc_pkg::UF_HIT];
    assign evicted    = m_axis_tuser[lkvc_pkg::UF_EVICTED];
    assign read_value = m_axis_tdata[VALUE_BITS-1:0];
    assign occupancy  = m_axis_tdata[FULL_AT-1:OCC_LO];
    assign is_full    = m_axis_tdata[FULL_AT];

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Drop any result after reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // An eviction only replaces on a miss into a full store
    a_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && evicted |-> !hit && is_full && (occupancy != '0))
        else $error("eviction on hit or non-full store");

    // A miss returns no data
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !hit |-> (read_value == '0))
        else $error("read data on a miss");

    // Full never reported on an empty store
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && is_full |-> (occupancy != '0))
        else $error("full flag with zero occupancy");

endmodule

bind lru_key_value_cache lkvc_checker #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .OUT_W      (OUT_W)
) u_lkvc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for lru_key_value_cache.
// It runs directed, capacity-edge and random traffic against an in-bench LRU predictor.
// Depends on lkvc_pkg and the lru_key_value_cache RTL.
module tb_top;

    localparam int ENTRIES    = 16;
    localparam int HALF_CYCLE = 6;
    localparam logic [31:0] KEY_ALL_ONES = 32'hFFFF_FFFF;

    // Expected content of one result transfer
    typedef struct packed {
        logic                       hit;
        logic [31:0]                read_value;
        logic                       evicted;
        logic [31:0]                evicted_key;
        logic [lkvc_pkg::OCC_W-1:0] occupancy;
        logic                       is_full;
    } t_cache_reply;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [lkvc_pkg::CAP_W-1:0]      i_cfg_wdata;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [63:0]                     s_axis_tdata;   // key, write_value
    logic [lkvc_pkg::MODE_W-1:0]     s_axis_tuser;   // mode
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [71:0]                     m_axis_tdata;   // read_value, evicted_key, occupancy,
                                                     // is_full
    logic [lkvc_pkg::OUT_USER_W-1:0] m_axis_tuser;   // hit, evicted

    lru_key_value_cache uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Predicted cache contents
    logic                       line_valid [ENTRIES];
    logic [31:0]                line_key   [ENTRIES];
    logic [31:0]                line_value [ENTRIES];
    int                         line_rank  [ENTRIES];
    int                         line_count;
    logic [lkvc_pkg::CAP_W-1:0] capacity_shadow;

    t_cache_reply replies_due[$];

    bit send_gaps_on;
    bit result_stalls_on;
    int stall_left;
    int mismatches;
    int items_sent;
    int results_seen;
    int hits_seen;
    int evictions_seen;
    int capacity_writes;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #HALF_CYCLE i_clk = ~i_clk;
    end

    // Generous run limit
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Mostly short idle stretches, a few long ones
    function automatic int idle_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Move one entry to the front of the recency order
    function automatic void make_most_recent(int s);
        int r;
        r = line_rank[s];
        for (int i = 0; i < ENTRIES; i++)
            if (line_valid[i] && i != s && line_rank[i] < r)
                line_rank[i]++;
        line_rank[s] = 0;
    endfunction

    // Apply one access to the predicted cache and return the reply it must produce
    function automatic t_cache_reply lru_apply(lkvc_pkg::t_mode op, logic [31:0] k,
                                               logic [31:0] v);
        t_cache_reply rep;
        int cap;
        int slot;
        int spot;
        rep  = '0;
        slot = -1;
        spot = -1;
        if (capacity_shadow == 0)
            cap = 1;
        else if (capacity_shadow > ENTRIES)
            cap = ENTRIES;
        else
            cap = int'(capacity_shadow);

        if (op == lkvc_pkg::MODE_CLEAR) begin
            for (int i = 0; i < ENTRIES; i++) begin
                line_valid[i] = 1'b0;
                line_rank[i]  = 0;
            end
            line_count = 0;
        end else begin
            for (int i = 0; i < ENTRIES; i++)
                if (slot < 0 && line_valid[i] && line_key[i] == k)
                    slot = i;
            if (slot >= 0) begin
                rep.hit = 1'b1;
                if (op == lkvc_pkg::MODE_PUT) begin
                    line_value[slot] = v;
                    make_most_recent(slot);
                end else begin
                    rep.read_value = line_value[slot];
                    if (op == lkvc_pkg::MODE_GET)
                        make_most_recent(slot);
                end
            end else if (op == lkvc_pkg::MODE_PUT) begin
                if (line_count < cap)
                    for (int i = 0; i < ENTRIES; i++)
                        if (spot < 0 && !line_valid[i])
                            spot = i;
                if (spot >= 0) begin
                    // insert into a free slot; everyone else ages by one
                    for (int i = 0; i < ENTRIES; i++)
                        if (line_valid[i])
                            line_rank[i]++;
                    line_valid[spot] = 1'b1;
                    line_key[spot]   = k;
                    line_value[spot] = v;
                    line_rank[spot]  = 0;
                    line_count++;
                end else begin
                    // replace the least recent entry
                    for (int i = 0; i < ENTRIES; i++)
                        if (line_valid[i] && (spot < 0 || line_rank[i] > line_rank[spot]))
                            spot = i;
                    if (spot >= 0) begin
                        rep.evicted      = 1'b1;
                        rep.evicted_key  = line_key[spot];
                        line_key[spot]   = k;
                        line_value[spot] = v;
                        make_most_recent(spot);
                    end
                end
            end
        end
        rep.occupancy = lkvc_pkg::OCC_W'(line_count);
        rep.is_full   = (line_count >= cap);
        return rep;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        $display("[%0t] MISMATCH result %0d %s: expected 0x%08h, got 0x%08h",
                 $realtime, results_seen, what, want, got);
    endtask

    // Drive one access and wait for its transfer; the predictor runs at that edge
    task automatic send_access(input lkvc_pkg::t_mode op, input logic [31:0] k,
                               input logic [31:0] v);
        int gap;
        gap = (send_gaps_on && $urandom_range(0, 99) < 45) ? idle_length() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {v, k};
        s_axis_tuser  = op;
        do @(posedge i_clk); while (!s_axis_tready);
        replies_due.push_back(lru_apply(op, k, v));
        items_sent++;
    endtask

    task automatic park_input();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Write capacity only once every outstanding result is back
    task automatic write_capacity(input logic [lkvc_pkg::CAP_W-1:0] c);
        park_input();
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = c;
        @(negedge i_clk);
        i_cfg_we        = 1'b0;
        capacity_shadow = c;
        capacity_writes++;
    endtask

    // Result stall pattern
    always @(negedge i_clk) begin
        if (stall_left > 0)
            stall_left--;
        else if (result_stalls_on && $urandom_range(0, 99) < 25)
            stall_left = idle_length();
        m_axis_tready = (stall_left == 0);
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_cache_reply got;
        t_cache_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit         = m_axis_tuser[lkvc_pkg::UF_HIT];
            got.evicted     = m_axis_tuser[lkvc_pkg::UF_EVICTED];
            got.read_value  = m_axis_tdata[31:0];
            got.evicted_key = m_axis_tdata[63:32];
            got.occupancy   = m_axis_tdata[64 +: lkvc_pkg::OCC_W];
            got.is_full     = m_axis_tdata[64 + lkvc_pkg::OCC_W];
            results_seen++;
            if (replies_due.size() == 0) begin
                report_mismatch("arrived with nothing outstanding", 32'd0, got.read_value);
            end else begin
                want = replies_due.pop_front();
                if (got.hit !== want.hit)
                    report_mismatch("hit", 32'(want.hit), 32'(got.hit));
                if (got.read_value !== want.read_value)
                    report_mismatch("read_value", want.read_value, got.read_value);
                if (got.evicted !== want.evicted)
                    report_mismatch("evicted", 32'(want.evicted), 32'(got.evicted));
                if (got.evicted_key !== want.evicted_key)
                    report_mismatch("evicted_key", want.evicted_key, got.evicted_key);
                if (got.occupancy !== want.occupancy)
                    report_mismatch("occupancy", 32'(want.occupancy), 32'(got.occupancy));
                if (got.is_full !== want.is_full)
                    report_mismatch("is_full", 32'(want.is_full), 32'(got.is_full));
                if (want.hit)
                    hits_seen++;
                if (want.evicted)
                    evictions_seen++;
            end
        end
    end

    // Every operation on an empty and a partly filled store, extreme keys and values
    task automatic test_basic_operations();
        send_access(lkvc_pkg::MODE_GET,   32'd0,        32'd0);
        send_access(lkvc_pkg::MODE_PROBE, KEY_ALL_ONES, 32'd0);
        send_access(lkvc_pkg::MODE_PUT,   32'd0,        KEY_ALL_ONES);
        send_access(lkvc_pkg::MODE_PUT,   KEY_ALL_ONES, 32'd0);
        send_access(lkvc_pkg::MODE_GET,   32'd0,        32'd0);
        send_access(lkvc_pkg::MODE_PROBE, KEY_ALL_ONES, KEY_ALL_ONES);
        send_access(lkvc_pkg::MODE_PUT,   32'd0,        32'h1234_5678);
        send_access(lkvc_pkg::MODE_GET,   32'd0,        32'd0);
        send_access(lkvc_pkg::MODE_CLEAR, KEY_ALL_ONES, KEY_ALL_ONES);
        send_access(lkvc_pkg::MODE_GET,   32'd0,        32'd0);
    endtask

    // Shrink capacity below occupancy: a put miss replaces, occupancy holds
    task automatic test_recency_after_shrink();
        write_capacity(5'd3);
        send_access(lkvc_pkg::MODE_CLEAR, 32'd0,  32'd0);
        send_access(lkvc_pkg::MODE_PUT,   32'd11, 32'hA1);
        send_access(lkvc_pkg::MODE_PUT,   32'd22, 32'hA2);
        send_access(lkvc_pkg::MODE_PUT,   32'd33, 32'hA3);
        send_access(lkvc_pkg::MODE_GET,   32'd11, 32'd0);
        write_capacity(5'd1);
        send_access(lkvc_pkg::MODE_PUT,   32'd44, 32'hA4);
        send_access(lkvc_pkg::MODE_PROBE, 32'd22, 32'd0);
        send_access(lkvc_pkg::MODE_PROBE, 32'd11, 32'd0);
    endtask

    // One-entry store, and a zero capacity that behaves as one
    task automatic test_minimum_capacity();
        send_access(lkvc_pkg::MODE_CLEAR, 32'd0, 32'd0);
        send_access(lkvc_pkg::MODE_PUT,   32'd5, 32'hB5);
        send_access(lkvc_pkg::MODE_PUT,   32'd6, 32'hB6);
        write_capacity(5'd0);
        send_access(lkvc_pkg::MODE_PUT,   32'd7, 32'hB7);
        send_access(lkvc_pkg::MODE_GET,   32'd7, 32'd0);
    endtask

    // Random accesses over a small key pool, one capacity per phase
    task automatic test_random_traffic();
        logic [lkvc_pkg::CAP_W-1:0] phase_caps [8];
        logic [31:0] key_pool [20];
        logic [31:0] k;
        int pick;
        lkvc_pkg::t_mode op;
        phase_caps = '{5'd16, 5'd31, 5'd0, 5'd17, 5'd1, 5'd2, 5'd10, 5'd7};
        phase_caps[7] = lkvc_pkg::CAP_W'($urandom_range(3, 15));
        for (int p = 0; p < 8; p++) begin
            write_capacity(phase_caps[p]);
            send_gaps_on     = (p % 4 < 2);
            result_stalls_on = (p % 2 == 0);
            foreach (key_pool[i])
                key_pool[i] = $urandom;
            key_pool[0] = 32'd0;
            key_pool[1] = KEY_ALL_ONES;
            repeat (75) begin
                pick = $urandom_range(0, 99);
                k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 19)];
                if (pick < 45)
                    op = lkvc_pkg::MODE_PUT;
                else if (pick < 70)
                    op = lkvc_pkg::MODE_GET;
                else if (pick < 90)
                    op = lkvc_pkg::MODE_PROBE;
                else if (pick < 93)
                    op = lkvc_pkg::MODE_CLEAR;
                else
                    op = lkvc_pkg::t_mode'(lkvc_pkg::MODE_W'($urandom_range(0, 3)));
                send_access(op, k, $urandom);
            end
        end
    endtask

    // Test sequence
    initial begin : run_tests
        int guard;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = lkvc_pkg::MODE_GET;
        send_gaps_on     = 1'b1;
        result_stalls_on = 1'b1;
        mismatches       = 0;
        items_sent       = 0;
        results_seen     = 0;
        hits_seen        = 0;
        evictions_seen   = 0;
        capacity_writes  = 0;
        capacity_shadow  = lkvc_pkg::CAPACITY_RESET;
        line_count       = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_key[i]   = '0;
            line_value[i] = '0;
            line_rank[i]  = 0;
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_operations();
        test_recency_after_shrink();
        test_minimum_capacity();
        test_random_traffic();

        // Drain remaining results
        park_input();
        guard = 0;
        while (replies_due.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (replies_due.size() != 0)
            report_mismatch("results never returned", 32'(replies_due.size()), 32'd0);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d accesses and %0d results (%0d hits, %0d evictions)",
                 items_sent, results_seen, hits_seen, evictions_seen);
        $display("Capacity was rewritten %0d times, including zero and saturating values",
                 capacity_writes);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lkvc_pkg.sv
rtl/lru_key_value_cache.sv
rtl/lkvc_checker.sv
dv/tb_top.sv
